### sv/bcle_pkg.sv
// Shared types, constants and helper functions for the book cipher letter encoder.
// No dependencies; every other file of the block uses this package.
package bcle_pkg;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // Output characters
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    // Letter ranges
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;

    // Positions stay below this limit, so four decimal digits always suffice
    localparam int POS_LIMIT   = 10000;
    localparam int NUM_DIGITS  = 4;
    localparam int DIG_IDX_W   = 2;
    localparam int DCOUNT_W    = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef logic [3:0]                  bcd_digit_t;
    typedef bcd_digit_t [NUM_DIGITS-1:0] bcd_num_t;
    typedef logic [DCOUNT_W-1:0]         dcount_t;

    // Position used for a letter that is absent from the key: 404 (sign added by the back end)
    localparam bcd_num_t NOT_FOUND_BCD  = {4'd0, 4'd4, 4'd0, 4'd4};
    localparam dcount_t  NOT_FOUND_NDIG = 3'd3;

    // One encode job handed from the front end to the back end
    typedef struct packed {
        logic       is_letter;
        logic       upper;
        logic       found;
        dcount_t    ndig;
        bcd_num_t   digits;
        logic [7:0] char_val;
    } job_t;

    // Increment a decimal counter by one
    function automatic bcd_num_t bcd_inc(input bcd_num_t v);
        bcd_num_t r;
        logic     carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (carry) begin
                if (v[i] == 4'd9) begin
                    r[i] = 4'd0;
                end else begin
                    r[i]  = v[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Number of significant decimal digits, at least one
    function automatic dcount_t sig_digits(input bcd_num_t v);
        dcount_t n;
        if (v[3] != 4'd0) begin
            n = 3'd4;
        end else if (v[2] != 4'd0) begin
            n = 3'd3;
        end else if (v[1] != 4'd0) begin
            n = 3'd2;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

endpackage

### sv/book_cipher_letter_encoder_top.sv
// Top level of the book cipher letter encoder: front end, job queue, back end.
// Depends on bcle_pkg, bcle_front, bcle_queue and bcle_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   s_      | in        | s_valid / s_ready  | s_command[1:0], s_in_char[7:0]
//   m_      | out       | m_valid / m_ready  | m_out_char[7:0], m_last
//
// Cycles: the front end takes one transfer per cycle while the two-entry job
// queue has room; append and clear finish in the cycle of their transfer.
// The back end sends one byte per cycle while m_ready allows: one byte for a non-letter,
// 3 to 7 bytes for a letter ('[', optional '-', '-' when absent, 1 to 4 digits, ']').
// Reset: aresetn (synchronous, active low) empties the key, queue and output.
// Stalls: m_ready low holds the output register; the queue lets the front end
// keep taking transfers until it fills, then s_ready drops.
module book_cipher_letter_encoder_top #(
    parameter int KEY_CAPACITY = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_in_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    bcle_pkg::job_t push_job;
    bcle_pkg::job_t q_job;

    // Accept transfers, update the key table, build encode jobs
    bcle_front #(
        .KEY_CAPACITY (KEY_CAPACITY)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_in_char (s_in_char),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    // Decouple the front end from output stalls
    bcle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // Expand jobs into bytes and drive the result channel
    bcle_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

### sv/bcle_front.sv
// Front end: accepts input transfers, keeps the key table and builds encode jobs.
// Depends on bcle_pkg.
module bcle_front #(
    parameter int KEY_CAPACITY = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [7:0]           s_in_char,
    input  logic                 q_full,
    output logic                 push,
    output bcle_pkg::job_t       push_job
);

    localparam int EFF_CAP = (KEY_CAPACITY > bcle_pkg::POS_LIMIT) ?
                             bcle_pkg::POS_LIMIT : KEY_CAPACITY;
    localparam int CNT_W   = $clog2(EFF_CAP + 1);
    localparam logic [CNT_W-1:0] CAP_VAL = CNT_W'(EFF_CAP);

    logic [CNT_W-1:0]                    count_reg, count_next;
    bcle_pkg::bcd_num_t                  bcd_reg, bcd_next;
    logic [bcle_pkg::NUM_LETTERS-1:0]    seen_reg, seen_next;
    bcle_pkg::bcd_num_t                  pos_mem [bcle_pkg::NUM_LETTERS];

    logic                                accept;
    logic                                is_lower, is_upper;
    logic [7:0]                          letter_off;
    logic [bcle_pkg::LETTER_W-1:0]       letter_idx;
    logic                                full;
    logic                                pos_we;
    bcle_pkg::bcd_num_t                  pos_rd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign is_lower   = (s_in_char >= bcle_pkg::CH_LOWER_A) && (s_in_char <= bcle_pkg::CH_LOWER_Z);
    assign is_upper   = (s_in_char >= bcle_pkg::CH_UPPER_A) && (s_in_char <= bcle_pkg::CH_UPPER_Z);
    assign letter_off = is_lower ? (s_in_char - bcle_pkg::CH_LOWER_A)
                                 : (s_in_char - bcle_pkg::CH_UPPER_A);
    assign letter_idx = letter_off[bcle_pkg::LETTER_W-1:0];
    assign full       = (count_reg == CAP_VAL);
    assign pos_rd     = pos_mem[letter_idx];

    always_comb begin
        count_next = count_reg;
        bcd_next   = bcd_reg;
        seen_next  = seen_reg;
        pos_we     = 1'b0;
        push       = 1'b0;
        if (accept) begin
            unique case (s_command)
                bcle_pkg::CMD_APPEND: begin
                    // drop key characters beyond capacity
                    if (!full) begin
                        count_next = count_reg + CNT_W'(1);
                        bcd_next   = bcle_pkg::bcd_inc(bcd_reg);
                        if (is_lower && !seen_reg[letter_idx]) begin
                            seen_next[letter_idx] = 1'b1;
                            pos_we                = 1'b1;
                        end
                    end
                end
                bcle_pkg::CMD_CLEAR: begin
                    count_next = '0;
                    bcd_next   = '0;
                    seen_next  = '0;
                end
                bcle_pkg::CMD_ENCODE: begin
                    push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Classify the message byte and look up its key position
    always_comb begin
        push_job           = '0;
        push_job.char_val  = s_in_char;
        push_job.is_letter = is_lower || is_upper;
        push_job.upper     = is_upper;
        push_job.found     = seen_reg[letter_idx];
        if (seen_reg[letter_idx]) begin
            push_job.digits = pos_rd;
            push_job.ndig   = bcle_pkg::sig_digits(pos_rd);
        end else begin
            push_job.digits = bcle_pkg::NOT_FOUND_BCD;
            push_job.ndig   = bcle_pkg::NOT_FOUND_NDIG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bcd_reg   <= '0;
            seen_reg  <= '0;
        end else begin
            count_reg <= count_next;
            bcd_reg   <= bcd_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[letter_idx] <= bcd_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_VAL)
        else $error("key count above capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_command == bcle_pkg::CMD_CLEAR) |=> (seen_reg == '0) && (count_reg == '0))
        else $error("clear left key state behind");
`endif

endmodule

### sv/bcle_queue.sv
// Short job queue between the front and back ends.
// Depends on bcle_pkg.
module bcle_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bcle_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output bcle_pkg::job_t q_job
);

    bcle_pkg::job_t                 slot_mem [bcle_pkg::QUEUE_DEPTH];
    logic [bcle_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bcle_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bcle_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == bcle_pkg::QCNT_W'(bcle_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_job   = slot_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + bcle_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + bcle_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + bcle_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - bcle_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && !q_valid))
        else $error("queue overflow or underflow");
`endif

endmodule

### sv/bcle_back.sv
// Back end: expands each job into output bytes, one per cycle unless m_ready stalls it, behind an output register.
// Depends on bcle_pkg.
module bcle_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  bcle_pkg::job_t q_job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_char,
    output logic           m_last
);

    typedef enum logic [5:0] {
        PH_PASS  = 6'b000001,
        PH_OPEN  = 6'b000010,
        PH_UDASH = 6'b000100,
        PH_NDASH = 6'b001000,
        PH_DIGIT = 6'b010000,
        PH_CLOSE = 6'b100000
    } phase_t;

    logic               busy_reg, busy_next;
    bcle_pkg::job_t     job_reg, job_next;
    phase_t             phase_reg, phase_next;
    bcle_pkg::dcount_t  dig_reg, dig_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;

    bcle_pkg::job_t                 cur_job;
    phase_t                         cur_phase, phase_after;
    bcle_pkg::dcount_t              cur_dig, dig_after, dig_less;
    logic [bcle_pkg::DIG_IDX_W-1:0] dig_sel;
    logic                           slot_free, emit, is_last;
    logic [7:0]                     out_byte;

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_last     = m_last_reg;

    // Work from the held job, or straight from the queue head when idle
    assign cur_job   = busy_reg ? job_reg : q_job;
    assign cur_phase = busy_reg ? phase_reg : (q_job.is_letter ? PH_OPEN : PH_PASS);
    assign cur_dig   = busy_reg ? dig_reg : q_job.ndig;
    assign dig_less  = cur_dig - bcle_pkg::DCOUNT_W'(1);
    assign dig_sel   = dig_less[bcle_pkg::DIG_IDX_W-1:0];

    assign slot_free = !m_valid_reg || m_ready;
    assign emit      = (busy_reg || q_valid) && slot_free;
    assign pop       = emit && !busy_reg;

    always_comb begin
        out_byte    = bcle_pkg::CH_CLOSE;
        is_last     = 1'b0;
        phase_after = cur_phase;
        dig_after   = cur_dig;
        unique case (cur_phase)
            PH_PASS: begin
                out_byte = cur_job.char_val;
                is_last  = 1'b1;
            end
            PH_OPEN: begin
                out_byte = bcle_pkg::CH_OPEN;
                if (cur_job.upper) begin
                    phase_after = PH_UDASH;
                end else if (!cur_job.found) begin
                    phase_after = PH_NDASH;
                end else begin
                    phase_after = PH_DIGIT;
                end
            end
            PH_UDASH: begin
                out_byte    = bcle_pkg::CH_DASH;
                phase_after = cur_job.found ? PH_DIGIT : PH_NDASH;
            end
            PH_NDASH: begin
                out_byte    = bcle_pkg::CH_DASH;
                phase_after = PH_DIGIT;
            end
            PH_DIGIT: begin
                out_byte    = bcle_pkg::CH_ZERO + 8'(cur_job.digits[dig_sel]);
                dig_after   = dig_less;
                phase_after = (cur_dig == bcle_pkg::DCOUNT_W'(1)) ? PH_CLOSE : PH_DIGIT;
            end
            PH_CLOSE: begin
                out_byte = bcle_pkg::CH_CLOSE;
                is_last  = 1'b1;
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        job_next     = job_reg;
        phase_next   = phase_reg;
        dig_next     = dig_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            busy_next    = !is_last;
            job_next     = cur_job;
            phase_next   = phase_after;
            dig_next     = dig_after;
            m_valid_next = 1'b1;
            m_char_next  = out_byte;
            m_last_next  = is_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_PASS;
            dig_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            phase_reg   <= phase_next;
            dig_reg     <= dig_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

`ifndef NO_ASSERTIONS
    a_digit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (phase_reg == PH_DIGIT) |-> (dig_reg != '0))
        else $error("digit phase with no digit left");

    a_no_park_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (phase_reg != PH_PASS) && (phase_reg != PH_OPEN))
        else $error("held job in a single-byte or opening phase");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for book_cipher_letter_encoder_top.
// Depends on bcle_pkg and the encoder RTL. A directed table runs first, then a key fill past capacity,
// then random key/message sequences; every transfer is checked against the table text or an in-line predictor.
module tb;
    import bcle_pkg::*;

    localparam int KEY_CAP       = 256;
    localparam int KEY_CAP_EFF   = (KEY_CAP > POS_LIMIT) ? POS_LIMIT : KEY_CAP;
    localparam int NOT_FOUND_POS = 404;
    localparam int RANDOM_ITEMS  = 40;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_WAIT      = 8;

    // Command value the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_byte_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [1:0] s_command  = CMD_APPEND;
    logic [7:0] s_in_char  = 8'h00;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last;

    // Encoder state as seen by the predictor
    int        key_len;
    int        letter_pos [NUM_LETTERS];
    bit        letter_known [NUM_LETTERS];

    out_byte_t encoded_bytes[$];  // bytes produced by the last predicted item
    out_byte_t pending_bytes[$];  // bytes still owed by the block, oldest first

    // Directed table
    logic [1:0] row_cmd[$];
    logic [7:0] row_char[$];
    string      row_text[$];

    int          errors      = 0;
    int unsigned cycle_count = 0;
    bit          send_burst  = 1'b0;
    bit          recv_burst  = 1'b0;

    always #1 aclk = ~aclk;

    book_cipher_letter_encoder_top #(
        .KEY_CAPACITY(KEY_CAP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_in_char (s_in_char),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_char(m_out_char),
        .m_last    (m_last)
    );

    function automatic void push_char(input logic [7:0] c);
        out_byte_t b;
        b.out_char = c;
        b.last     = 1'b0;
        encoded_bytes.push_back(b);
    endfunction

    // Work out the bytes one input item causes and advance the key state.
    function automatic void book_encode(input logic [1:0] cmd, input logic [7:0] ch);
        string     digits;
        int        idx;
        bit        upper;
        bit        lower;
        out_byte_t tail;
        encoded_bytes.delete();
        upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);
        lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
        case (cmd)
            CMD_APPEND: begin
                // drop the character once the key is full; only lowercase gets recorded
                if (key_len < KEY_CAP_EFF) begin
                    if (lower) begin
                        idx = ch - CH_LOWER_A;
                        if (!letter_known[idx]) begin
                            letter_known[idx] = 1'b1;
                            letter_pos[idx]   = key_len;
                        end
                    end
                    key_len++;
                end
            end
            CMD_CLEAR: begin
                key_len = 0;
                for (int i = 0; i < NUM_LETTERS; i++) begin
                    letter_known[i] = 1'b0;
                    letter_pos[i]   = 0;
                end
            end
            CMD_ENCODE: begin
                if (upper || lower) begin
                    idx = upper ? ch - CH_UPPER_A : ch - CH_LOWER_A;
                    push_char(CH_OPEN);
                    if (upper) begin
                        push_char(CH_DASH);
                    end
                    if (letter_known[idx]) begin
                        digits = $sformatf("%0d", letter_pos[idx]);
                    end else begin
                        push_char(CH_DASH);
                        digits = $sformatf("%0d", NOT_FOUND_POS);
                    end
                    for (int i = 0; i < digits.len(); i++) begin
                        push_char(digits[i]);
                    end
                    push_char(CH_CLOSE);
                end else begin
                    push_char(ch);
                end
                tail      = encoded_bytes.pop_back();
                tail.last = 1'b1;
                encoded_bytes.push_back(tail);
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] rand_lower();
        return CH_LOWER_A + 8'($urandom_range(0, NUM_LETTERS - 1));
    endfunction

    function automatic logic [7:0] rand_upper();
        return CH_UPPER_A + 8'($urandom_range(0, NUM_LETTERS - 1));
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [7:0] ch,
                                    input string text);
        row_cmd.push_back(cmd);
        row_char.push_back(ch);
        row_text.push_back(text);
    endfunction

    // Present one item, hold it until the transfer, then queue what it owes.
    // A non-empty text replaces the predicted bytes for that item.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch, input string text);
        int        gap;
        out_byte_t b;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_in_char <= ch;
        do @(posedge aclk); while (!s_ready);
        book_encode(cmd, ch);
        if (text.len() == 0) begin
            foreach (encoded_bytes[i]) pending_bytes.push_back(encoded_bytes[i]);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                b.out_char = text[i];
                b.last     = (i == text.len() - 1);
                pending_bytes.push_back(b);
            end
        end
    endtask

    // Random key character: mostly lowercase, some uppercase, some arbitrary bytes
    function automatic logic [7:0] rand_key_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return rand_lower();
        end else if (r < 15) begin
            return rand_upper();
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Random message byte: mostly letters, the rest anything
    function automatic logic [7:0] rand_msg_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return rand_lower();
        end else if (r < 7) begin
            return rand_upper();
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Cycle counter: end the run if it never drains
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: stall at random, then take one transfer and check it
    // against the oldest owed byte.
    initial begin
        int        stall;
        out_byte_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait(recv_burst);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual out_char %h last %b",
                         $time, m_out_char, m_last);
                errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_out_char !== want.out_char) begin
                    $display("%0t: out_char mismatch, expected %h actual %h",
                             $time, want.out_char, m_out_char);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // Input side: reset, directed table, long key fill, random sequences, drain.
    initial begin
        int         counted;
        int         key_items;
        int         msg_items;
        logic [7:0] ch;

        key_len = 0;
        for (int i = 0; i < NUM_LETTERS; i++) begin
            letter_known[i] = 1'b0;
            letter_pos[i]   = 0;
        end

        // Empty key after reset: every letter is absent
        add_row(CMD_ENCODE, "a", "[-404]");
        add_row(CMD_ENCODE, "Z", "[--404]");
        // Byte extremes and the neighbors of the letter ranges pass through
        add_row(CMD_ENCODE, 8'h00, "");
        add_row(CMD_ENCODE, 8'hFF, "");
        add_row(CMD_ENCODE, 8'h80, "");
        add_row(CMD_ENCODE, 8'h60, "");
        add_row(CMD_ENCODE, 8'h7B, "");
        add_row(CMD_ENCODE, 8'h40, "");
        add_row(CMD_ENCODE, 8'h5B, "");
        // Key "bAbz<80>": uppercase and high bytes take a position but never match
        add_row(CMD_APPEND, "b", "");
        add_row(CMD_APPEND, "A", "");
        add_row(CMD_APPEND, "b", "");
        add_row(CMD_APPEND, "z", "");
        add_row(CMD_APPEND, 8'h80, "");
        add_row(CMD_ENCODE, "b", "[0]");
        add_row(CMD_ENCODE, "B", "[-0]");
        add_row(CMD_ENCODE, "a", "[-404]");
        add_row(CMD_ENCODE, "z", "[3]");
        // Unused command: nothing comes out, nothing changes
        add_row(CMD_UNUSED, "a", "");
        add_row(CMD_ENCODE, "Z", "[-3]");
        // Clear empties the key
        add_row(CMD_CLEAR, 8'hFF, "");
        add_row(CMD_ENCODE, "b", "[-404]");
        add_row(CMD_APPEND, "q", "");
        add_row(CMD_ENCODE, "Q", "[-0]");

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (row_cmd[i]) begin
            send_item(row_cmd[i], row_char[i], row_text[i]);
        end

        // Fill past capacity: non-lowercase bytes first so letters land at high
        // positions, then letters, the tail of which gets dropped.
        send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), "");
        for (int i = 0; i < KEY_CAP_EFF + 4; i++) begin
            if (i < KEY_CAP_EFF - 60) begin
                do ch = 8'($urandom_range(0, 255));
                while (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
            end else begin
                ch = rand_lower();
            end
            send_item(CMD_APPEND, ch, "");
        end
        for (int i = 0; i < NUM_LETTERS; i++) begin
            ch = ($urandom_range(0, 1) == 1) ? CH_UPPER_A + 8'(i) : CH_LOWER_A + 8'(i);
            send_item(CMD_ENCODE, ch, "");
        end

        // Random sequences: usually clear, build a key, then encode a message
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), "");
                counted++;
            end
            key_items = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48)
                                                    : $urandom_range(0, 24);
            for (int i = 0; i < key_items; i++) begin
                send_item(CMD_APPEND, rand_key_char(), "");
            end
            msg_items = $urandom_range(1, 10);
            for (int i = 0; i < msg_items; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), "");
                end
                send_item(CMD_ENCODE, rand_msg_char(), "");
            end
            counted += key_items + msg_items;
        end
        s_valid <= 1'b0;

        // Wait for every owed byte, then watch a little longer for strays
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/bcle_pkg.sv
sv/bcle_front.sv
sv/bcle_queue.sv
sv/bcle_back.sv
sv/book_cipher_letter_encoder_top.sv
test/tb.sv
